// ===== src/lzwd_pkg.sv =====
// Shared constants and controller/datapath handshake types for the LZW dictionary trie.
package lzwd_pkg;

   // Dictionary geometry.
   localparam int DICT_SIZE = 4096;
   localparam int CODE_W    = $clog2(DICT_SIZE);
   localparam int COUNT_W   = CODE_W + 1;
   localparam int BYTE_W    = 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;   // latch the accepted byte and the start node
      logic load_first;  // latch the child list head and tail of the start node
      logic step_walk;   // move the walk pointer to the next sibling
      logic set_hit;     // commit a match on the walked node
      logic set_full;    // record a miss in a full dictionary
      logic add_one;     // first write cycle of a new node
      logic add_two;     // second write cycle of a new node, links it in
      logic emit;        // load the pending result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic first_zero;  // the start node has no children
      logic byte_hit;    // the walked node carries the input byte
      logic sib_zero;    // the walked node has no next sibling
      logic full;        // every code is in use
      logic rsp_busy;    // the output register holds a result not yet taken
   } sts_type;

endpackage

// ===== src/lzwd_if.sv =====
// Valid/ready channel interfaces for input bytes and lookup results.

interface lzwd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lzwd_pkg::BYTE_W-1:0]   next_char;
   logic                          restart;

   modport source (output valid, output next_char, output restart, input ready);
   modport sink (input valid, input next_char, input restart, output ready);
endinterface

interface lzwd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          matched;
   logic [lzwd_pkg::CODE_W-1:0]   code;
   logic                          added;
   logic                          full_res;

   modport source (output valid, output matched, output code, output added,
                   output full_res, input ready);
   modport sink (input valid, input matched, input code, input added,
                 input full_res, output ready);
endinterface

// ===== src/lzw_trie_dictionary_step_top.sv =====
// LZW dictionary trie step: one input byte per lookup, one result per byte.
// The dictionary holds up to 4096 codes as a trie in four single-port-write
// RAMs (edge byte, first child, next sibling and last child of each node);
// code 0 is the root. Each accepted byte is looked up among the children of
// the current node (or of the root when restart is set) by walking the child
// list one node per clock, one read of the byte and sibling tables per step.
// A hit on the k-th child, or a miss after k children in a full dictionary,
// ends the walk, and a miss that adds a node then writes the tables in
// states ADD1 and ADD2; a new byte is taken only once the lookup is done.
// The walk length sets the rate: up to 256 children per node. A finished
// result sits in an output register, and the next byte is accepted while it
// waits to be taken. The tables need no clearing pass after reset.
module lzw_trie_dictionary_step_top (
   input logic        clock,
   input logic        reset,
   lzwd_req_if.sink   req_chan,
   lzwd_rsp_if.source rsp_chan
);

   lzwd_pkg::cmd_type cmd;
   lzwd_pkg::sts_type sts;
   logic              req_ready;

   assign req_chan.ready = req_ready;

   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzwd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .next_char (req_chan.next_char),
      .restart   (req_chan.restart),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   // A node is never added once every code is in use.
   a_no_add_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.add_two |-> !sts.full)
      else $error("node added to a full dictionary");

   // A match is committed only on a node that carries the input byte.
   a_hit_on_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.set_hit |-> sts.byte_hit)
      else $error("match committed without a byte hit");

   // The two insertion write cycles always follow each other.
   a_add_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.add_one |=> cmd.add_two)
      else $error("insertion sequence broken");

   // After a byte transfer, no new byte is taken until its lookup is done.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("byte accepted while a lookup is in progress");
`endif

endmodule

// ===== src/lzwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lzwd_ctrl.sv =====
// Controller state machine: sequences the lookup, child-list walk and node insertion.
module lzwd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::sts_type sts,
   output lzwd_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_ADD1  = 3'd3;
   localparam logic [2:0] S_ADD2  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_FIRST;
            end
         end
         S_FIRST: begin
            cmd.load_first = 1'b1;
            if (!sts.first_zero) begin
               state_in = S_CMP;
            end else if (sts.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_OUT;
            end else begin
               state_in = S_ADD1;
            end
         end
         S_CMP: begin
            if (sts.byte_hit) begin
               cmd.set_hit = 1'b1;
               state_in    = S_OUT;
            end else if (!sts.sib_zero) begin
               cmd.step_walk = 1'b1;
            end else if (sts.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_OUT;
            end else begin
               state_in = S_ADD1;
            end
         end
         S_ADD1: begin
            cmd.add_one = 1'b1;
            state_in    = S_ADD2;
         end
         S_ADD2: begin
            cmd.add_two = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/lzwd_dpath.sv =====
// Datapath: trie tables, walk pointer, node counter and the result output register.
module lzwd_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lzwd_pkg::BYTE_W-1:0] next_char,
   input  logic                        restart,
   input  lzwd_pkg::cmd_type           cmd,
   output lzwd_pkg::sts_type           sts,
   lzwd_rsp_if.source                  rsp_chan
);

   localparam int CW = lzwd_pkg::CODE_W;
   localparam int BW = lzwd_pkg::BYTE_W;
   localparam int NW = lzwd_pkg::COUNT_W;

   // Item and walk registers.
   logic [BW-1:0] ch_ff;
   logic [CW-1:0] cur_ff;
   logic [CW-1:0] current_ff;
   logic [NW-1:0] count_ff;
   logic          root_ok_ff;
   logic [CW-1:0] first_ff;
   logic [CW-1:0] last_ff;
   logic [CW-1:0] walk_ff;

   // Pending result and output register.
   logic          res_matched_ff;
   logic [CW-1:0] res_code_ff;
   logic          res_added_ff;
   logic          res_full_ff;
   logic          rsp_valid_ff;
   logic          rsp_matched_ff;
   logic [CW-1:0] rsp_code_ff;
   logic          rsp_added_ff;
   logic          rsp_full_ff;

   // Table ports.
   logic [CW-1:0] start_node;
   logic [CW-1:0] fresh;
   logic [CW-1:0] first_rdata;
   logic [CW-1:0] last_rdata;
   logic [CW-1:0] first_val;
   logic [BW-1:0] byte_rdata;
   logic [CW-1:0] sib_rdata;
   logic [CW-1:0] walk_addr;

   logic          byte_we;
   logic          sib_we;
   logic [CW-1:0] sib_waddr;
   logic [CW-1:0] sib_wdata;
   logic          first_we;
   logic [CW-1:0] first_waddr;
   logic [CW-1:0] first_wdata;
   logic          last_we;

   // The restart flag returns the lookup to the root.
   assign start_node = restart ? '0 : current_ff;
   assign fresh      = count_ff[CW-1:0];

   // The root's first-child entry reads as empty until it is first written.
   assign first_val = ((cur_ff == '0) && !root_ok_ff) ? '0 : first_rdata;
   assign walk_addr = cmd.load_first ? first_val : sib_rdata;

   // Insertion writes: the new node first, then the link from its parent list.
   always_comb begin
      byte_we     = cmd.add_one;
      last_we     = cmd.add_one;
      sib_we      = 1'b0;
      sib_waddr   = fresh;
      sib_wdata   = '0;
      first_we    = 1'b0;
      first_waddr = fresh;
      first_wdata = '0;
      if (cmd.add_one) begin
         sib_we   = 1'b1;
         first_we = 1'b1;
      end else if (cmd.add_two) begin
         if (first_ff == '0) begin
            first_we    = 1'b1;
            first_waddr = cur_ff;
            first_wdata = fresh;
         end else begin
            sib_we    = 1'b1;
            sib_waddr = last_ff;
            sib_wdata = fresh;
         end
      end
   end

   lzwd_ram #(.WIDTH(BW), .DEPTH(lzwd_pkg::DICT_SIZE)) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (fresh),
      .wr_data (ch_ff),
      .rd_addr (walk_addr),
      .rd_data (byte_rdata)
   );

   lzwd_ram #(.WIDTH(CW), .DEPTH(lzwd_pkg::DICT_SIZE)) u_sib_ram (
      .clock   (clock),
      .wr_en   (sib_we),
      .wr_addr (sib_waddr),
      .wr_data (sib_wdata),
      .rd_addr (walk_addr),
      .rd_data (sib_rdata)
   );

   lzwd_ram #(.WIDTH(CW), .DEPTH(lzwd_pkg::DICT_SIZE)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (first_waddr),
      .wr_data (first_wdata),
      .rd_addr (start_node),
      .rd_data (first_rdata)
   );

   lzwd_ram #(.WIDTH(CW), .DEPTH(lzwd_pkg::DICT_SIZE)) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .wr_addr (cur_ff),
      .wr_data (fresh),
      .rd_addr (start_node),
      .rd_data (last_rdata)
   );

   // Status back to the controller.
   assign sts.first_zero = (first_val == '0);
   assign sts.byte_hit   = (byte_rdata == ch_ff);
   assign sts.sib_zero   = (sib_rdata == '0);
   assign sts.full       = (count_ff == NW'(lzwd_pkg::DICT_SIZE));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_chan.ready;

   // Control state: current node, code counter, root link flag, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= '0;
         count_ff     <= NW'(1);
         root_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            current_ff <= start_node;
         end else if (cmd.set_hit) begin
            current_ff <= walk_ff;
         end
         if (cmd.add_two) begin
            count_ff <= count_ff + NW'(1);
            if ((first_ff == '0) && (cur_ff == '0)) begin
               root_ok_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         ch_ff  <= next_char;
         cur_ff <= start_node;
      end
      if (cmd.load_first) begin
         first_ff <= first_val;
         last_ff  <= last_rdata;
         walk_ff  <= first_val;
      end else if (cmd.step_walk) begin
         walk_ff <= sib_rdata;
      end
      if (cmd.set_hit) begin
         res_matched_ff <= 1'b1;
         res_code_ff    <= walk_ff;
         res_added_ff   <= 1'b0;
         res_full_ff    <= 1'b0;
      end else if (cmd.set_full) begin
         res_matched_ff <= 1'b0;
         res_code_ff    <= '0;
         res_added_ff   <= 1'b0;
         res_full_ff    <= 1'b1;
      end else if (cmd.add_two) begin
         res_matched_ff <= 1'b0;
         res_code_ff    <= '0;
         res_added_ff   <= 1'b1;
         res_full_ff    <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_matched_ff <= res_matched_ff;
         rsp_code_ff    <= res_code_ff;
         rsp_added_ff   <= res_added_ff;
         rsp_full_ff    <= res_full_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.matched  = rsp_matched_ff;
   assign rsp_chan.code     = rsp_code_ff;
   assign rsp_chan.added    = rsp_added_ff;
   assign rsp_chan.full_res = rsp_full_ff;

endmodule
